@@ rtl/core/forward_backward_speed_profile_assert.svh @@
// Assertion macros for the speed profile block
`ifndef FORWARD_BACKWARD_SPEED_PROFILE_ASSERT_SVH
`define FORWARD_BACKWARD_SPEED_PROFILE_ASSERT_SVH

// same-cycle implication
`define FBSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbsp check failed");

// next-cycle implication
`define FBSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbsp check failed");

`endif

@@ rtl/core/fbsp_pkg.sv @@
package fbsp_pkg;

	localparam int AR_W      = 52;
	localparam int DIV_ITERS = 52;
	localparam int SQ_ITERS  = 26;
	localparam int Q_CHUNKS  = 3;

	localparam logic [22:0] DIV_BY_125 = 23'd125;
	localparam logic [23:0] RECIP_125  = 24'd8589935;
	localparam logic [14:0] MAG_SAT    = 15'h7FFF;

	localparam logic [15:0] FRICTION_RST = 16'd13107;
	localparam logic [15:0] GRAVITY_RST  = 16'd2511;
	localparam logic [15:0] VMAX_RST     = 16'd7680;
	localparam logic [15:0] VINIT_RST    = 16'd0;

	localparam logic [2:0] REG_FRICTION = 3'd0;
	localparam logic [2:0] REG_GRAVITY  = 3'd1;
	localparam logic [2:0] REG_VMAX     = 3'd2;
	localparam logic [2:0] REG_VINIT    = 3'd3;
	localparam logic [2:0] REG_ENABLE   = 3'd4;

	typedef struct packed {
		logic [23:0]        arc_length;
		logic signed [19:0] curvature;
		logic               last_point;
	} fbsp_req_t;

	typedef struct packed {
		logic [5:0]         point_index;
		logic [15:0]        speed;
		logic signed [15:0] accel;
		logic               truncated;
		logic               last_result;
	} fbsp_res_t;

	typedef enum logic {
		AR_DIV,
		AR_SQRT
	} fbsp_ar_op_t;

	typedef struct packed {
		logic            start;
		fbsp_ar_op_t     op;
		logic [AR_W-1:0] a;
		logic [19:0]     d;
	} fbsp_ar_cmd_t;

	typedef struct packed {
		logic            done;
		logic [AR_W-1:0] result;
	} fbsp_ar_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PMUL,
		ST_AMUL,
		ST_AMAX2,
		ST_C_RD,
		ST_C_CHK,
		ST_C_DIVW,
		ST_C_SQW,
		ST_INIT,
		ST_P_RDC,
		ST_P_RDN,
		ST_P_LAT,
		ST_P_CHK,
		ST_VV,
		ST_VK,
		ST_LAT,
		ST_LL,
		ST_SQ,
		ST_SQW,
		ST_DS,
		ST_DIV,
		ST_QMUL,
		ST_DIVW,
		ST_RAD,
		ST_RTW,
		ST_WR,
		ST_E_RD,
		ST_E_OUT
	} fbsp_state_t;

	function automatic logic [19:0] curv_abs(input logic signed [19:0] k);
		logic [19:0] r;
		r = k[19] ? (~k + 20'd1) : k;
		return r;
	endfunction

endpackage

@@ rtl/core/fbsp_arith.sv @@
module fbsp_arith
	import fbsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  fbsp_ar_cmd_t cmd,
	output fbsp_ar_sts_t sts
);

	fbsp_ar_op_t     op_q;
	logic [AR_W-1:0] x_q;
	logic [19:0]     d_q;
	logic [29:0]     rem_q;
	logic [25:0]     root_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [20:0] dsh;
	logic        dge;
	logic [29:0] ssh;
	logic [29:0] trial;
	logic        sge;
	logic [5:0]  last_cnt;

	assign dsh      = {rem_q[19:0], x_q[AR_W-1]};
	assign dge      = dsh >= {1'b0, d_q};
	assign ssh      = {rem_q[27:0], x_q[AR_W-1:AR_W-2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign sge      = ssh >= trial;
	assign last_cnt = (op_q == AR_DIV) ? 6'(DIV_ITERS - 1) : 6'(SQ_ITERS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && cmd.start) begin
			op_q   <= cmd.op;
			x_q    <= cmd.a;
			d_q    <= cmd.d;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (op_q == AR_DIV) begin
				rem_q <= {10'd0, dge ? 20'(dsh - {1'b0, d_q}) : dsh[19:0]};
				x_q   <= {x_q[AR_W-2:0], dge};
			end else begin
				rem_q  <= sge ? (ssh - trial) : ssh;
				root_q <= {root_q[24:0], sge};
				x_q    <= {x_q[AR_W-3:0], 2'b00};
			end
		end
	end

	assign sts.done   = done_q;
	assign sts.result = (op_q == AR_DIV) ? x_q : AR_W'(root_q);

endmodule

@@ rtl/core/forward_backward_speed_profile.sv @@
// Loading: one point per cycle, busy stays low until the last point.
// Planning: a curvature limit per point (a divide and a square root, skipped
// when it is zero), then each acceleration pass (square roots and a divide by
// 125 where a point is limited), then the results. The bound is the shared
// divide/square-root unit. Results cannot be stalled. Reset clears control
// state and registers to defaults; point stores are not cleared.
module forward_backward_speed_profile
	import fbsp_pkg::*;
#(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  fbsp_req_t   req,
	output logic        res_valid,
	output fbsp_res_t   res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [15:0] fc_q, g_q, vmax_q, vinit_q;
	logic        en_q;

	fbsp_state_t state_q, state_d;
	logic [IW-1:0] i_q;
	logic [CW-1:0] n_q, count_q;
	logic          ovf_q, bwd_q;
	logic [31:0]   p_q;
	logic [25:0]   amax_q;
	logic [51:0]   amax2_q;
	logic [15:0]   spd_c_q, spd_n_q;
	logic [23:0]   arc_c_q, arc_n_q;
	logic [19:0]   kabs_q;
	logic [31:0]   vv_q;
	logic [25:0]   lat_q;
	logic [14:0]   mag_q;
	logic [20:0]   nv_q;
	logic [63:0]   mul_q;
	logic [47:0]   dvd_q, quo_q;
	logic [6:0]    rem7_q;
	logic [22:0]   t_q;
	logic [1:0]    qn_q;
	logic          res_valid_q;
	fbsp_res_t     res_q;

	logic [23:0]        arc_mem [MAX_POINTS];
	logic signed [19:0] curv_mem [MAX_POINTS];
	logic [15:0]        spd_mem [MAX_POINTS];
	logic [15:0]        acc_mem [MAX_POINTS];
	logic [23:0]        arc_rd;
	logic signed [19:0] curv_rd;
	logic [15:0]        spd_rd, acc_rd;

	logic [IW-1:0] rd_addr, spd_wa, acc_wa, nb;
	logic          ld_we, spd_we, acc_we;
	logic [15:0]   spd_wd, acc_wd;
	logic [31:0]   mul_a, mul_b;
	fbsp_ar_cmd_t  ar_cmd;
	fbsp_ar_sts_t  ar_sts;

	logic [CW-1:0] i_ext;
	logic          full, last_pt, pass_last;
	logic [19:0]   kabs_rd;
	logic [35:0]   lat;
	logic [24:0]   ds, ds_abs;
	logic [17:0]   mroot;
	logic [41:0]   rad;
	logic [IW+5:0] pix;
	logic [22:0]   q_t, q125;
	logic [15:0]   qc;

	assign i_ext     = CW'(i_q);
	assign full      = count_q == CW'(MAX_POINTS);
	assign last_pt   = i_ext == n_q - CW'(1);
	assign nb        = bwd_q ? i_q - IW'(1) : i_q + IW'(1);
	assign pass_last = bwd_q ? (i_q == IW'(1)) : (i_ext == n_q - CW'(2));
	assign kabs_rd   = curv_abs(curv_rd);
	assign lat       = mul_q[51:16];
	assign ds        = bwd_q ? ({1'b0, arc_c_q} - {1'b0, arc_n_q})
	                         : ({1'b0, arc_n_q} - {1'b0, arc_c_q});
	assign ds_abs    = ds[24] ? (~ds + 25'd1) : ds;
	assign mroot     = ar_sts.result[25:8];
	assign rad       = ds[24] ? (42'(vv_q) - 42'(quo_q[40:0]))
	                          : (42'(vv_q) + 42'(quo_q[40:0]));
	assign pix       = (IW + 6)'(i_q);
	// divide by 125 in 16-bit digits, reciprocal multiply per digit
	assign q_t       = {rem7_q, dvd_q[47:32]};
	assign qc        = mul_q[45:30];
	assign q125      = 23'(qc) * DIV_BY_125;

	fbsp_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ar_cmd),
		.sts    (ar_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q    <= FRICTION_RST;
			g_q     <= GRAVITY_RST;
			vmax_q  <= VMAX_RST;
			vinit_q <= VINIT_RST;
			en_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRICTION: fc_q    <= cfg_wdata;
				REG_GRAVITY:  g_q     <= cfg_wdata;
				REG_VMAX:     vmax_q  <= cfg_wdata;
				REG_VINIT:    vinit_q <= cfg_wdata;
				REG_ENABLE:   en_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			arc_mem[count_q[IW-1:0]]  <= req.arc_length;
			curv_mem[count_q[IW-1:0]] <= req.curvature;
		end
		if (spd_we) begin
			spd_mem[spd_wa] <= spd_wd;
		end
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
		arc_rd  <= arc_mem[rd_addr];
		curv_rd <= curv_mem[rd_addr];
		spd_rd  <= spd_mem[rd_addr];
		acc_rd  <= acc_mem[rd_addr];
		mul_q   <= 64'(mul_a) * 64'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= state_q == ST_E_OUT;
			if (state_q == ST_IDLE && start) begin
				if (full) begin
					ovf_q <= 1'b1;
				end
				if (req.last_point) begin
					count_q <= '0;
				end else if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (state_q == ST_E_OUT && last_pt) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= full ? count_q : count_q + CW'(1);
				i_q <= '0;
			end
			ST_AMUL: begin
				p_q    <= mul_q[31:0];
				amax_q <= mul_q[31:6];
			end
			ST_AMAX2: amax2_q <= mul_q[51:0];
			ST_C_CHK: if (kabs_rd == '0 && !last_pt) i_q <= i_q + IW'(1);
			ST_C_SQW: if (ar_sts.done && !last_pt) i_q <= i_q + IW'(1);
			ST_INIT: begin
				i_q   <= '0;
				bwd_q <= 1'b0;
			end
			ST_P_RDN: begin
				spd_c_q <= spd_rd;
				arc_c_q <= arc_rd;
			end
			ST_P_LAT: begin
				spd_n_q <= spd_rd;
				arc_n_q <= arc_rd;
				kabs_q  <= kabs_rd;
			end
			ST_VK: vv_q <= mul_q[31:0];
			ST_LAT: begin
				if (lat >= 36'(amax_q)) begin
					mag_q <= '0;
				end
				lat_q <= lat[25:0];
			end
			ST_SQW: if (ar_sts.done) mag_q <= (mroot > 18'(MAG_SAT)) ? MAG_SAT : mroot[14:0];
			ST_DIV: begin
				dvd_q  <= {2'b00, mul_q[39:0], 6'd0};
				quo_q  <= '0;
				rem7_q <= '0;
				qn_q   <= '0;
			end
			ST_QMUL: t_q <= q_t;
			ST_DIVW: begin
				quo_q  <= {quo_q[31:0], qc};
				rem7_q <= 7'(t_q - q125);
				dvd_q  <= {dvd_q[31:0], 16'd0};
				qn_q   <= qn_q + 2'd1;
			end
			ST_RAD: nv_q <= '0;
			ST_RTW: if (ar_sts.done) nv_q <= ar_sts.result[20:0];
			ST_E_OUT: begin
				res_q.point_index <= pix[5:0];
				res_q.speed       <= spd_rd;
				res_q.accel       <= acc_rd;
				res_q.truncated   <= ovf_q;
				res_q.last_result <= last_pt;
				i_q               <= i_q + IW'(1);
			end
			default: ;
		endcase
		if (state_q == ST_P_CHK || state_q == ST_WR) begin
			if (state_d == ST_P_RDC) begin
				if (!bwd_q && pass_last) begin
					bwd_q <= 1'b1;
					i_q   <= IW'(n_q - CW'(1));
				end else begin
					i_q <= bwd_q ? i_q - IW'(1) : i_q + IW'(1);
				end
			end
		end
		if (state_d == ST_E_RD && state_q != ST_E_OUT) begin
			i_q <= '0;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_addr   = i_q;
		ld_we     = 1'b0;
		spd_we    = 1'b0;
		spd_wa    = i_q;
		spd_wd    = '0;
		acc_we    = 1'b0;
		acc_wa    = i_q;
		acc_wd    = '0;
		mul_a     = '0;
		mul_b     = '0;
		ar_cmd    = '{start: 1'b0, op: AR_DIV, a: '0, d: '0};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ld_we = !full;
					if (req.last_point) begin
						state_d = ST_PMUL;
					end
				end
			end
			ST_PMUL: begin
				mul_a   = 32'(fc_q);
				mul_b   = 32'(g_q);
				state_d = ST_AMUL;
			end
			ST_AMUL: begin
				mul_a   = 32'(mul_q[31:6]);
				mul_b   = 32'(mul_q[31:6]);
				state_d = ST_AMAX2;
			end
			ST_AMAX2: state_d = ST_C_RD;
			ST_C_RD: state_d = ST_C_CHK;
			ST_C_CHK: begin
				if (kabs_rd == '0) begin
					spd_we = 1'b1;
					spd_wd = vmax_q;
					acc_we = 1'b1;
					if (!last_pt) begin
						state_d = ST_C_RD;
					end else begin
						state_d = en_q ? ST_INIT : ST_E_RD;
					end
				end else begin
					ar_cmd  = '{start: 1'b1, op: AR_DIV, a: AR_W'({p_q, 10'd0}), d: kabs_rd};
					state_d = ST_C_DIVW;
				end
			end
			ST_C_DIVW: begin
				if (ar_sts.done) begin
					ar_cmd  = '{start: 1'b1, op: AR_SQRT, a: ar_sts.result, d: '0};
					state_d = ST_C_SQW;
				end
			end
			ST_C_SQW: begin
				if (ar_sts.done) begin
					spd_we = 1'b1;
					spd_wd = (ar_sts.result < AR_W'(vmax_q)) ? ar_sts.result[15:0] : vmax_q;
					acc_we = 1'b1;
					if (!last_pt) begin
						state_d = ST_C_RD;
					end else begin
						state_d = en_q ? ST_INIT : ST_E_RD;
					end
				end
			end
			ST_INIT: begin
				spd_we  = 1'b1;
				spd_wa  = '0;
				spd_wd  = vinit_q;
				state_d = (n_q == CW'(1)) ? ST_E_RD : ST_P_RDC;
			end
			ST_P_RDC: state_d = ST_P_RDN;
			ST_P_RDN: begin
				rd_addr = nb;
				state_d = ST_P_LAT;
			end
			ST_P_LAT: state_d = ST_P_CHK;
			ST_P_CHK: begin
				if (spd_n_q > spd_c_q) begin
					state_d = ST_VV;
				end else begin
					state_d = (bwd_q && pass_last) ? ST_E_RD : ST_P_RDC;
				end
			end
			ST_VV: begin
				mul_a   = 32'(spd_c_q);
				mul_b   = 32'(spd_c_q);
				state_d = ST_VK;
			end
			ST_VK: begin
				mul_a   = mul_q[31:0];
				mul_b   = 32'(kabs_q);
				state_d = ST_LAT;
			end
			ST_LAT: state_d = (lat >= 36'(amax_q)) ? ST_DS : ST_LL;
			ST_LL: begin
				mul_a   = 32'(lat_q);
				mul_b   = 32'(lat_q);
				state_d = ST_SQ;
			end
			ST_SQ: begin
				ar_cmd  = '{start: 1'b1, op: AR_SQRT, a: amax2_q - mul_q[51:0], d: '0};
				state_d = ST_SQW;
			end
			ST_SQW: if (ar_sts.done) state_d = ST_DS;
			ST_DS: begin
				mul_a   = 32'(mag_q);
				mul_b   = 32'(ds_abs);
				state_d = ST_DIV;
			end
			ST_DIV: state_d = ST_QMUL;
			ST_QMUL: begin
				mul_a   = 32'(q_t);
				mul_b   = 32'(RECIP_125);
				state_d = ST_DIVW;
			end
			ST_DIVW: state_d = (qn_q == 2'(Q_CHUNKS - 1)) ? ST_RAD : ST_QMUL;
			ST_RAD: begin
				if (rad[41] || rad == '0) begin
					state_d = ST_WR;
				end else begin
					ar_cmd  = '{start: 1'b1, op: AR_SQRT, a: AR_W'(rad[40:0]), d: '0};
					state_d = ST_RTW;
				end
			end
			ST_RTW: if (ar_sts.done) state_d = ST_WR;
			ST_WR: begin
				acc_we = 1'b1;
				acc_wd = bwd_q ? (~{1'b0, mag_q} + 16'd1) : {1'b0, mag_q};
				if (nv_q < 21'(spd_n_q)) begin
					spd_we = 1'b1;
					spd_wa = nb;
					spd_wd = nv_q[15:0];
				end
				state_d = (bwd_q && pass_last) ? ST_E_RD : ST_P_RDC;
			end
			ST_E_RD: state_d = ST_E_OUT;
			ST_E_OUT: state_d = last_pt ? ST_IDLE : ST_E_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy      = state_q != ST_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/core/fbsp_check.sv @@
`include "forward_backward_speed_profile_assert.svh"

module fbsp_check
	import fbsp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input fbsp_req_t req,
	input logic      res_valid,
	input fbsp_res_t res
);

	`FBSP_ASSERT_IMP(a_mid_result_busy, res_valid && !res.last_result, busy)
	`FBSP_ASSERT_IMP(a_final_result_idle, res_valid && res.last_result, !busy)
	`FBSP_ASSERT_NXT(a_load_stays_ready, start && !busy && !req.last_point, !busy)
	`FBSP_ASSERT_NXT(a_last_starts_run, start && !busy && req.last_point, busy)
	`FBSP_ASSERT_NXT(a_result_gap, res_valid && !res.last_result, !res_valid)

endmodule

bind forward_backward_speed_profile fbsp_check u_fbsp_check (.*);
